### sv/sfsbt_pkg.sv
package sfsbt_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam int REQ_W   = 3;
    localparam int ID_W    = 32;
    localparam int RATE_W  = 32;
    localparam int TOTAL_W = 23;
    localparam int ACNT_W  = 5;

    localparam int KBPS_W  = 10;
    localparam int PROD_W  = TOTAL_W + KBPS_W;
    localparam int QUO_W   = 32;
    localparam int STEP_W  = $clog2(QUO_W);

    localparam logic [KBPS_W-1:0]  KBPS_PER_MBPS = KBPS_W'(1000);
    localparam logic [TOTAL_W-1:0] RESET_TOTAL   = TOTAL_W'(100);

    localparam logic [REQ_W-1:0] REQ_ADD        = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ALLOCATE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REALLOCATE = 3'd4;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [ID_W-1:0]    flow_id;
        logic [RATE_W-1:0]  initial_bitrate;
        logic [TOTAL_W-1:0] bandwidth_mbps;
    } req_t;

    typedef struct packed {
        logic              status;
        logic [RATE_W-1:0] bitrate_out;
        logic [ACNT_W-1:0] active_count;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic idx_inc;
        logic add_wr;
        logic rm_clr;
        logic rate_take;
        logic set_ok;
        logic div_load;
        logic div_step;
        logic share_wr;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             slot_free;
        logic             hit;
        logic             idx_last;
        logic             count_zero;
        logic             div_last;
    } stat_t;

endpackage

### sv/sfsbt_ctrl.sv
module sfsbt_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sfsbt_pkg::REQ_W-1:0] start_type,
    input  sfsbt_pkg::stat_t            stat,
    output sfsbt_pkg::cmd_t             cmd,
    output logic                        busy,
    output logic                        done
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_FREE  = 8'b0000_0010,
        ST_LOOK  = 8'b0000_0100,
        ST_CMP   = 8'b0000_1000,
        ST_LOAD  = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_SHARE = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (start_type)
                        sfsbt_pkg::REQ_ADD:        state_next = ST_FREE;
                        sfsbt_pkg::REQ_REMOVE:     state_next = ST_LOOK;
                        sfsbt_pkg::REQ_QUERY:      state_next = ST_LOOK;
                        sfsbt_pkg::REQ_ALLOCATE:   state_next = ST_LOAD;
                        sfsbt_pkg::REQ_REALLOCATE: state_next = ST_LOAD;
                        default:                   state_next = ST_DONE;
                    endcase
                end
            end
            ST_FREE:
            begin
                if (stat.slot_free)
                begin
                    cmd.add_wr = 1'b1;
                    cmd.set_ok = 1'b1;
                    state_next = ST_DONE;
                end
                else if (stat.idx_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (stat.hit)
                begin
                    cmd.set_ok = 1'b1;
                    if (stat.req_type == sfsbt_pkg::REQ_REMOVE)
                    begin
                        cmd.rm_clr = 1'b1;
                    end
                    else
                    begin
                        cmd.rate_take = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else if (stat.idx_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_LOOK;
                end
            end
            ST_LOAD:
            begin
                cmd.set_ok = 1'b1;
                if (stat.count_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_SHARE;
                end
            end
            ST_SHARE:
            begin
                cmd.share_wr = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

### sv/sfsbt_dp.sv
module sfsbt_dp #(
    parameter int SLOT_COUNT = sfsbt_pkg::SLOT_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sfsbt_pkg::req_t   req,
    input  sfsbt_pkg::cmd_t   cmd,
    output sfsbt_pkg::stat_t  stat,
    output sfsbt_pkg::rsp_t   rsp
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    // request capture
    logic [sfsbt_pkg::REQ_W-1:0]  type_reg;
    logic [sfsbt_pkg::ID_W-1:0]   id_reg;
    logic [sfsbt_pkg::RATE_W-1:0] init_reg;

    // slot table
    logic [SLOT_COUNT-1:0]        valid_reg;
    logic [SLOT_COUNT-1:0]        valid_next;
    logic [sfsbt_pkg::ID_W-1:0]   ident_mem [SLOT_COUNT];
    logic [sfsbt_pkg::RATE_W-1:0] rate_mem  [SLOT_COUNT];
    logic [sfsbt_pkg::ID_W-1:0]   ident_q_reg;
    logic [sfsbt_pkg::RATE_W-1:0] rate_q_reg;
    logic                         rate_we;
    logic [sfsbt_pkg::RATE_W-1:0] rate_wd;

    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [sfsbt_pkg::TOTAL_W-1:0] total_reg;
    logic [sfsbt_pkg::TOTAL_W-1:0] total_next;

    // divider
    logic [sfsbt_pkg::PROD_W-1:0] prod;
    logic [sfsbt_pkg::QUO_W-1:0]  quo_reg;
    logic [sfsbt_pkg::QUO_W-1:0]  quo_next;
    logic [CNT_W-1:0]             rem_reg;
    logic [CNT_W-1:0]             rem_next;
    logic [CNT_W:0]               rem_sh;
    logic [CNT_W:0]               rem_diff;
    logic [sfsbt_pkg::STEP_W-1:0] step_reg;
    logic [sfsbt_pkg::STEP_W-1:0] step_next;

    // result
    logic                         status_reg;
    logic                         status_next;
    logic [sfsbt_pkg::RATE_W-1:0] bitrate_reg;
    logic [sfsbt_pkg::RATE_W-1:0] bitrate_next;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg <= req.req_type;
            id_reg   <= req.flow_id;
            init_reg <= req.initial_bitrate;
        end
    end

    assign rate_we = cmd.add_wr | (cmd.share_wr & valid_reg[idx_reg]);
    assign rate_wd = cmd.add_wr ? init_reg : quo_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.add_wr)
        begin
            ident_mem[idx_reg] <= id_reg;
        end
        if (rate_we)
        begin
            rate_mem[idx_reg] <= rate_wd;
        end
        ident_q_reg <= ident_mem[idx_reg];
        rate_q_reg  <= rate_mem[idx_reg];
    end

    assign prod = sfsbt_pkg::PROD_W'(total_reg) * sfsbt_pkg::PROD_W'(sfsbt_pkg::KBPS_PER_MBPS);

    assign rem_sh   = {rem_reg, quo_reg[sfsbt_pkg::QUO_W-1]};
    assign rem_diff = rem_sh - {1'b0, count_reg};

    always_comb
    begin
        valid_next   = valid_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        status_next  = status_reg;
        bitrate_next = bitrate_reg;

        if (cmd.load)
        begin
            idx_next     = '0;
            status_next  = sfsbt_pkg::STATUS_FAIL;
            bitrate_next = '0;
            if (req.req_type == sfsbt_pkg::REQ_ALLOCATE)
            begin
                total_next = req.bandwidth_mbps;
            end
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (cmd.add_wr)
        begin
            valid_next[idx_reg] = 1'b1;
            count_next          = count_reg + CNT_W'(1);
        end
        if (cmd.rm_clr)
        begin
            valid_next[idx_reg] = 1'b0;
            count_next          = count_reg - CNT_W'(1);
        end
        if (cmd.rate_take)
        begin
            bitrate_next = rate_q_reg;
        end
        if (cmd.set_ok)
        begin
            status_next = sfsbt_pkg::STATUS_OK;
        end
        if (cmd.div_load)
        begin
            quo_next  = prod[sfsbt_pkg::QUO_W-1:0];
            rem_next  = '0;
            step_next = '0;
        end
        if (cmd.div_step)
        begin
            step_next = step_reg + sfsbt_pkg::STEP_W'(1);
            if (rem_sh >= {1'b0, count_reg})
            begin
                rem_next = rem_diff[CNT_W-1:0];
                quo_next = {quo_reg[sfsbt_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[CNT_W-1:0];
                quo_next = {quo_reg[sfsbt_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            idx_reg     <= '0;
            count_reg   <= '0;
            total_reg   <= sfsbt_pkg::RESET_TOTAL;
            step_reg    <= '0;
            status_reg  <= sfsbt_pkg::STATUS_FAIL;
            bitrate_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            step_reg    <= step_next;
            status_reg  <= status_next;
            bitrate_reg <= bitrate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign stat.req_type   = type_reg;
    assign stat.slot_free  = ~valid_reg[idx_reg];
    assign stat.hit        = valid_reg[idx_reg] && (ident_q_reg == id_reg);
    assign stat.idx_last   = (idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign stat.count_zero = (count_reg == '0);
    assign stat.div_last   = (step_reg == sfsbt_pkg::STEP_W'(sfsbt_pkg::QUO_W - 1));

    assign rsp.status       = status_reg;
    assign rsp.bitrate_out  = bitrate_reg;
    assign rsp.active_count = sfsbt_pkg::ACNT_W'(count_reg);

endmodule

### sv/stream_fair_share_bandwidth_table.sv
// add scans for a free slot, remove and query compare the id slot by slot, unknown goes to done;
// allocate and reallocate end with no active slot, else run the 32-step divider, then write shares
// the next item is taken in the cycle after done; busy rises after accept and stays high through done
// one result per item, shown for one cycle with done; the receiver cannot stall
// reset clears the slot table and count and sets the total to 100 Mbps
module stream_fair_share_bandwidth_table #(
    parameter int SLOT_COUNT = sfsbt_pkg::SLOT_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  sfsbt_pkg::req_t req,
    output logic            done,
    output sfsbt_pkg::rsp_t rsp
);

    sfsbt_pkg::cmd_t  cmd;
    sfsbt_pkg::stat_t stat;

    sfsbt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_type (req.req_type),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done)
    );

    sfsbt_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

### sv/sfsbt_chk.sv
module sfsbt_chk #(
    parameter int SLOT_COUNT = sfsbt_pkg::SLOT_COUNT_DEF
) (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            done,
    input sfsbt_pkg::rsp_t rsp
);

    // an accepted item raises busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result without an item in work");

    assert property (@(posedge clk) disable iff (!rst_n) done |=> (!busy && !done))
        else $error("block not free after result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.bitrate_out != '0)) |-> (rsp.status == sfsbt_pkg::STATUS_OK))
        else $error("bitrate reported on a failed item");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((SLOT_COUNT > 31) || (rsp.active_count <= 5'(SLOT_COUNT))))
        else $error("active count above slot count");

endmodule

bind stream_fair_share_bandwidth_table sfsbt_chk #(
    .SLOT_COUNT (SLOT_COUNT)
) u_sfsbt_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam logic [sfsbt_pkg::REQ_W-1:0] REQ_UNKNOWN_FIRST = 3'd5;
    localparam logic [sfsbt_pkg::REQ_W-1:0] REQ_UNKNOWN_LAST  = 3'd7;
    localparam int                          WATCHDOG_LIMIT    = 2000;
    localparam int                          RANDOM_ITEMS      = 550;
    localparam int                          CALM_TAIL         = 80;
    localparam int                          ID_POOL_SIZE      = 6;

    typedef struct {
        sfsbt_pkg::req_t item;
        bit              known;
        sfsbt_pkg::rsp_t want;
    } probe_t;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic            done;
    sfsbt_pkg::req_t req_in;
    sfsbt_pkg::rsp_t rsp_out;

    // mirror of the stream table
    logic                           slot_used [sfsbt_pkg::SLOT_COUNT_DEF];
    logic [sfsbt_pkg::ID_W-1:0]     slot_id   [sfsbt_pkg::SLOT_COUNT_DEF];
    logic [sfsbt_pkg::RATE_W-1:0]   slot_kbps [sfsbt_pkg::SLOT_COUNT_DEF];
    logic [31:0]                    streams_live;
    logic [sfsbt_pkg::TOTAL_W-1:0]  total_mbps;

    sfsbt_pkg::rsp_t            rsp_backlog [$];
    probe_t                     probes [$];
    logic [sfsbt_pkg::ID_W-1:0] id_pool [ID_POOL_SIZE];

    int errors;
    int items_sent;
    int results_seen;
    int full_adds;
    int id_misses;
    int shares_done;
    int unknown_reqs;
    int idle_cycles;

    stream_fair_share_bandwidth_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req_in),
        .done  (done),
        .rsp   (rsp_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic sfsbt_pkg::rsp_t share_table_apply(sfsbt_pkg::req_t r);
        sfsbt_pkg::rsp_t o;
        int              hit;
        logic [31:0]     share;
        o.status = sfsbt_pkg::STATUS_FAIL;
        o.bitrate_out = '0;
        hit = -1;
        case (r.req_type)
            sfsbt_pkg::REQ_ADD:
            begin
                for (int i = sfsbt_pkg::SLOT_COUNT_DEF - 1; i >= 0; i--)
                    if (!slot_used[i])
                        hit = i;
                if (hit >= 0)
                begin
                    slot_used[hit] = 1'b1;
                    slot_id[hit] = r.flow_id;
                    slot_kbps[hit] = r.initial_bitrate;
                    streams_live = streams_live + 1;
                    o.status = sfsbt_pkg::STATUS_OK;
                end
            end
            sfsbt_pkg::REQ_REMOVE, sfsbt_pkg::REQ_QUERY:
            begin
                for (int i = sfsbt_pkg::SLOT_COUNT_DEF - 1; i >= 0; i--)
                    if (slot_used[i] && slot_id[i] == r.flow_id)
                        hit = i;
                if (hit >= 0)
                begin
                    o.status = sfsbt_pkg::STATUS_OK;
                    if (r.req_type == sfsbt_pkg::REQ_QUERY)
                        o.bitrate_out = slot_kbps[hit];
                    else
                    begin
                        slot_used[hit] = 1'b0;
                        if (streams_live != 0)
                            streams_live = streams_live - 1;
                    end
                end
            end
            sfsbt_pkg::REQ_ALLOCATE, sfsbt_pkg::REQ_REALLOCATE:
            begin
                if (r.req_type == sfsbt_pkg::REQ_ALLOCATE)
                    total_mbps = r.bandwidth_mbps;
                if (streams_live != 0)
                begin
                    // product wraps at 32 bits before the divide
                    share = {9'd0, total_mbps} * 32'd1000;
                    share = share / streams_live;
                    for (int i = 0; i < sfsbt_pkg::SLOT_COUNT_DEF; i++)
                        if (slot_used[i])
                            slot_kbps[i] = share;
                end
                o.status = sfsbt_pkg::STATUS_OK;
            end
            default:
            begin
            end
        endcase
        o.active_count = streams_live[sfsbt_pkg::ACNT_W-1:0];
        return o;
    endfunction

    function automatic sfsbt_pkg::req_t random_request(int add_pct);
        sfsbt_pkg::req_t r;
        int              pick;
        int              bw_pick;
        pick = $urandom_range(0, 99);
        if (pick < add_pct)
            r.req_type = sfsbt_pkg::REQ_ADD;
        else if (pick < 60)
            r.req_type = sfsbt_pkg::REQ_REMOVE;
        else if (pick < 80)
            r.req_type = sfsbt_pkg::REQ_QUERY;
        else if (pick < 88)
            r.req_type = sfsbt_pkg::REQ_ALLOCATE;
        else if (pick < 95)
            r.req_type = sfsbt_pkg::REQ_REALLOCATE;
        else
            r.req_type = sfsbt_pkg::REQ_W'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
        r.flow_id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, ID_POOL_SIZE - 1)]
                                                  : $urandom;
        r.initial_bitrate = $urandom;
        bw_pick = $urandom_range(0, 99);
        if (bw_pick < 5)
            r.bandwidth_mbps = '0;
        else if (bw_pick < 10)
            r.bandwidth_mbps = '1;
        else if (bw_pick < 25)
            r.bandwidth_mbps = sfsbt_pkg::TOTAL_W'($urandom);
        else if (bw_pick < 60)
            r.bandwidth_mbps = sfsbt_pkg::TOTAL_W'($urandom_range(0, 5000));
        else
            r.bandwidth_mbps = sfsbt_pkg::TOTAL_W'($urandom_range(0, 4294967));
        return r;
    endfunction

    task automatic add_probe(input logic [sfsbt_pkg::REQ_W-1:0] t,
                             input logic [sfsbt_pkg::ID_W-1:0] id,
                             input logic [sfsbt_pkg::RATE_W-1:0] kbps,
                             input logic [sfsbt_pkg::TOTAL_W-1:0] mbps,
                             input bit known, input logic st,
                             input logic [sfsbt_pkg::RATE_W-1:0] br,
                             input logic [sfsbt_pkg::ACNT_W-1:0] cnt);
        probe_t p;
        p.item.req_type = t;
        p.item.flow_id = id;
        p.item.initial_bitrate = kbps;
        p.item.bandwidth_mbps = mbps;
        p.known = known;
        p.want.status = st;
        p.want.bitrate_out = br;
        p.want.active_count = cnt;
        probes.push_back(p);
    endtask

    task automatic issue(input sfsbt_pkg::req_t item, input bit known,
                         input sfsbt_pkg::rsp_t want, input int gap_pct);
        sfsbt_pkg::rsp_t predicted;
        start <= 1'b1;
        req_in <= item;
        do
            @(posedge clk);
        while (busy);
        predicted = share_table_apply(item);
        rsp_backlog.push_back(known ? want : predicted);
        items_sent++;
        if (item.req_type == sfsbt_pkg::REQ_ADD && predicted.status == sfsbt_pkg::STATUS_FAIL)
            full_adds++;
        if ((item.req_type == sfsbt_pkg::REQ_REMOVE || item.req_type == sfsbt_pkg::REQ_QUERY)
            && predicted.status == sfsbt_pkg::STATUS_FAIL)
            id_misses++;
        if ((item.req_type == sfsbt_pkg::REQ_ALLOCATE
             || item.req_type == sfsbt_pkg::REQ_REALLOCATE)
            && predicted.active_count != 0)
            shares_done++;
        if (item.req_type >= REQ_UNKNOWN_FIRST)
            unknown_reqs++;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        sfsbt_pkg::rsp_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (rsp_backlog.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual %0h", $time, rsp_out);
            end
            else
            begin
                want = rsp_backlog.pop_front();
                check_field("status", 32'(want.status), 32'(rsp_out.status));
                check_field("bitrate_out", want.bitrate_out, rsp_out.bitrate_out);
                check_field("active_count", 32'(want.active_count), 32'(rsp_out.active_count));
            end
        end
    end

    // stall detector
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int              add_pct;
        int              gap_pct;
        sfsbt_pkg::rsp_t none;
        items_sent = 0;
        full_adds = 0;
        id_misses = 0;
        shares_done = 0;
        unknown_reqs = 0;
        none = '0;
        for (int i = 0; i < sfsbt_pkg::SLOT_COUNT_DEF; i++)
        begin
            slot_used[i] = 1'b0;
            slot_id[i] = '0;
            slot_kbps[i] = '0;
        end
        streams_live = 0;
        total_mbps = sfsbt_pkg::RESET_TOTAL;
        for (int i = 0; i < ID_POOL_SIZE; i++)
            id_pool[i] = $urandom;
        id_pool[0] = '0;
        id_pool[1] = '1;

        rst_n = 1'b0;
        start = 1'b0;
        req_in = '0;

        // empty table
        add_probe(sfsbt_pkg::REQ_QUERY, 32'h0, 32'h0, 23'd0, 1'b1, sfsbt_pkg::STATUS_FAIL,
                  32'h0, 5'd0);
        add_probe(sfsbt_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'h0, 23'd0, 1'b1,
                  sfsbt_pkg::STATUS_FAIL, 32'h0, 5'd0);
        add_probe(sfsbt_pkg::REQ_REALLOCATE, 32'h0, 32'h0, 23'd0, 1'b1, sfsbt_pkg::STATUS_OK,
                  32'h0, 5'd0);
        add_probe(sfsbt_pkg::REQ_ALLOCATE, 32'h0, 32'h0, 23'h7F_FFFF, 1'b1,
                  sfsbt_pkg::STATUS_OK, 32'h0, 5'd0);
        add_probe(REQ_UNKNOWN_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 23'h7F_FFFF, 1'b1,
                  sfsbt_pkg::STATUS_FAIL, 32'h0, 5'd0);
        // extremes and a duplicate id
        add_probe(sfsbt_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 23'd0, 1'b1,
                  sfsbt_pkg::STATUS_OK, 32'h0, 5'd1);
        add_probe(sfsbt_pkg::REQ_ADD, 32'h0, 32'h0, 23'd0, 1'b1, sfsbt_pkg::STATUS_OK,
                  32'h0, 5'd2);
        add_probe(sfsbt_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'h1, 23'd0, 1'b1, sfsbt_pkg::STATUS_OK,
                  32'h0, 5'd3);
        add_probe(sfsbt_pkg::REQ_QUERY, 32'hFFFF_FFFF, 32'h0, 23'd0, 1'b1,
                  sfsbt_pkg::STATUS_OK, 32'hFFFF_FFFF, 5'd3);
        // stored total above range, share wraps
        add_probe(sfsbt_pkg::REQ_REALLOCATE, 32'h0, 32'h0, 23'd0, 1'b0, sfsbt_pkg::STATUS_OK,
                  32'h0, 5'd0);
        add_probe(sfsbt_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'h0, 23'd0, 1'b1,
                  sfsbt_pkg::STATUS_OK, 32'h0, 5'd2);
        add_probe(sfsbt_pkg::REQ_QUERY, 32'hFFFF_FFFF, 32'h0, 23'd0, 1'b0,
                  sfsbt_pkg::STATUS_OK, 32'h0, 5'd0);
        // fill to the top, then one add too many
        for (int k = 3; k <= sfsbt_pkg::SLOT_COUNT_DEF; k++)
            add_probe(sfsbt_pkg::REQ_ADD, 32'h1000_0000 + k, k * 1000, 23'd0, 1'b1,
                      sfsbt_pkg::STATUS_OK, 32'h0, sfsbt_pkg::ACNT_W'(k));
        add_probe(sfsbt_pkg::REQ_ADD, 32'h5A5A_5A5A, 32'h1234, 23'd0, 1'b1,
                  sfsbt_pkg::STATUS_FAIL, 32'h0,
                  sfsbt_pkg::ACNT_W'(sfsbt_pkg::SLOT_COUNT_DEF));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[n])
            issue(probes[n].item, probes[n].known, probes[n].want, 20);

        add_pct = 45;
        gap_pct = 20;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                add_pct = (add_pct == 45) ? 15 : 45;
            if (n % 50 == 0)
                gap_pct = $urandom_range(0, 3) * 15;
            if (n >= RANDOM_ITEMS - CALM_TAIL)
                gap_pct = 0;
            if (n == RANDOM_ITEMS / 2)
            begin
                start <= 1'b0;
                while (rsp_backlog.size() != 0)
                    @(posedge clk);
            end
            issue(random_request(add_pct), 1'b0, none, gap_pct);
        end

        start <= 1'b0;
        while (rsp_backlog.size() != 0)
            @(posedge clk);
        repeat (sfsbt_pkg::SLOT_COUNT_DEF + 40) @(posedge clk);

        $display("covered %0d items and %0d results: %0d adds to a full table, %0d id misses",
                 items_sent, results_seen, full_adds, id_misses);
        $display("%0d equal-share passes over live streams, %0d unknown requests",
                 shares_done, unknown_reqs);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
sv/sfsbt_pkg.sv
sv/sfsbt_ctrl.sv
sv/sfsbt_dp.sv
sv/stream_fair_share_bandwidth_table.sv
sv/sfsbt_chk.sv
test/tb_top.sv
